// File: rtl/ivfs_pkg.sv
// Shared constants and types for the partitioned nearest-neighbor search engine.
`timescale 1ns / 1ps
package ivfs_pkg;
    localparam int DIM      = 16;
    localparam int NPART    = 16;
    localparam int CAPACITY = 1024;
    localparam int MAX_K    = 16;

    localparam int CW   = $clog2(DIM);
    localparam int PW   = $clog2(NPART);
    localparam int IW   = $clog2(CAPACITY);
    localparam int KW   = $clog2(MAX_K);
    localparam int DW   = 36;
    localparam int LW   = 11;
    localparam int VW   = 16;
    localparam int CFGW = 5;

    localparam logic [DW-1:0] DIST_MAX = '1;
    localparam logic [LW-1:0] LABEL_NONE = '1;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic          vld;
        logic [DW-1:0] sqd;
        logic [LW-1:0] label;
    } cand_t;

    typedef struct packed {
        logic                 vld;
        logic                 first;
        logic                 last;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
    } dist_in_t;
endpackage

// File: rtl/ivfs_dist.sv
// Pipelined squared L2 distance accumulator, one component per cycle.
`timescale 1ns / 1ps
module ivfs_dist (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ivfs_pkg::dist_in_t       din,
    output logic                     out_vld,
    output logic [ivfs_pkg::DW-1:0]  out_sum
);
    import ivfs_pkg::*;

    logic signed [VW:0]      diff_reg;
    logic                    v1_reg, f1_reg, l1_reg;
    logic [2*VW+1:0]         sq_reg;
    logic                    v2_reg, f2_reg, l2_reg;
    logic [DW-1:0]           acc_reg;
    logic                    ov_reg;
    logic [DW:0]             acc_sum;
    logic [DW-1:0]           acc_next;
    logic signed [2*VW+1:0]  prod;

    assign prod    = diff_reg * diff_reg;
    assign acc_sum = (f2_reg ? {(DW+1){1'b0}} : {1'b0, acc_reg})
                   + {{(DW-2*VW-1){1'b0}}, sq_reg};
    assign acc_next = acc_sum[DW] ? DIST_MAX : acc_sum[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= din.vld;
            v2_reg <= v1_reg;
            ov_reg <= v2_reg && l2_reg;
        end
        f1_reg   <= din.first;
        l1_reg   <= din.last;
        diff_reg <= {din.a[VW-1], din.a} - {din.b[VW-1], din.b};
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        sq_reg   <= prod;
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign out_vld = ov_reg;
    assign out_sum = acc_reg;
endmodule

// File: rtl/ivfs_cell.sv
// One cell of the sorted best-neighbor chain; keeps the smaller, passes the other on.
`timescale 1ns / 1ps
module ivfs_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clr,
    input  ivfs_pkg::cand_t     cand_in,
    output ivfs_pkg::cand_t     cand_out,
    output ivfs_pkg::cand_t     entry
);
    import ivfs_pkg::*;

    cand_t ent_reg;
    cand_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            ent_reg.vld <= 1'b0;
            out_reg.vld <= 1'b0;
        end else if (cand_in.vld) begin
            if (!ent_reg.vld || cand_in.sqd < ent_reg.sqd) begin
                ent_reg <= cand_in;
                out_reg <= ent_reg;
            end else begin
                out_reg <= cand_in;
            end
        end else begin
            out_reg.vld <= 1'b0;
        end
    end

    assign cand_out = out_reg;
    assign entry    = ent_reg;
endmodule

// File: rtl/ivf_flat_nearest_search.sv
// Top level: partitioned nearest-neighbor search engine with centroid and vector stores.
// One beat carries one component. Loads, clears and non-final components are taken
// without leaving the idle state. An add to a store that is not full runs 16 centroid
// distances through the single multiply-accumulate unit and writes 16 words to the
// vector store. A query on a non-empty store computes the centroid distances, scans all
// partitions once per probed partition for selection, then checks the tag of every stored
// vector, runs each vector in a probed partition through the unit, drains the neighbor
// chain and sends one result beat per neighbor. The unit is fed by one vector store read port.
// No clearing pass after reset.
`timescale 1ns / 1ps
module ivf_flat_nearest_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // partition_sel[3:0], component[7:4], value[23:8]
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // label[10:0], partition[14:11], distance[50:15],
                                   // status[52:51], zero pad
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ivfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CDIST, S_ADDWR, S_PSEL, S_TAG, S_CHK, S_ISS, S_WAIT,
        S_DRAIN, S_ONE, S_EMIT
    } state_t;

    state_t state_reg;

    logic [CFGW-1:0] pc_reg, tk_reg;
    logic [CFGW-1:0] np, kk;

    assign pready = 1'b1;
    assign prdata = {{(32-CFGW){1'b0}}, paddr[2] ? tk_reg : pc_reg};
    assign np = (pc_reg == '0) ? CFGW'(1) : (pc_reg > CFGW'(NPART)) ? CFGW'(NPART) : pc_reg;
    assign kk = (tk_reg == '0) ? CFGW'(1) : (tk_reg > CFGW'(MAX_K)) ? CFGW'(MAX_K) : tk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= CFGW'(1);
            tk_reg <= CFGW'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) tk_reg <= pwdata[CFGW-1:0];
            else          pc_reg <= pwdata[CFGW-1:0];
        end
    end

    logic [1:0]    in_mode;
    logic [PW-1:0] in_sel;
    logic [CW-1:0] in_comp;
    logic [VW-1:0] in_val;
    logic          in_acc;

    assign in_mode = s_tuser;
    assign in_sel  = s_tdata[3:0];
    assign in_comp = s_tdata[7:4];
    assign in_val  = s_tdata[23:8];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc  = s_tvalid && s_tready;

    logic signed [VW-1:0] pend_reg [DIM];
    always_ff @(posedge aclk) begin
        if (in_acc && (in_mode == MODE_ADD || in_mode == MODE_QUERY)) begin
            pend_reg[in_comp] <= in_val;
        end
    end

    logic [IW:0]    count_reg;
    logic [PW+CW-1:0] ic_reg;
    logic           issuing_reg;
    logic [PW-1:0]  rc_reg;
    logic [PW-1:0]  best_p_reg;
    logic [DW-1:0]  best_d_reg;
    logic [DW-1:0]  pd_reg [NPART];
    logic [NPART-1:0] mask_reg;
    logic [CFGW-1:0]  pi_reg;
    logic [PW-1:0]  pp_reg;
    logic           found_reg;
    logic [DW-1:0]  bd_reg;
    logic [PW-1:0]  pick_reg;
    logic [IW:0]    id_reg;
    logic [CW-1:0]  c_reg;
    logic [KW:0]    oi_reg;
    logic [LW-1:0]  o_label_reg;
    logic [PW-1:0]  o_part_reg;
    logic [DW-1:0]  o_dist_reg;
    logic [1:0]     o_status_reg;
    logic           o_kind_reg;
    logic           m_tvalid_reg;
    logic [55:0]    m_tdata_reg;
    logic           m_tuser_reg;
    logic           m_tlast_reg;
    logic           is_query_reg;
    logic           clr_chain;
    cand_t          inj;

    // centroid store with per-word valid bits
    logic [VW-1:0]           cmem [NPART*DIM];
    logic [NPART*DIM-1:0]    cval_reg;
    logic [VW-1:0]           cmem_q;
    logic                    cval_q;
    logic                    cwr;
    logic [PW+CW-1:0]        cwaddr;

    assign cwr    = in_acc && in_mode == MODE_LOAD;
    assign cwaddr = {in_sel, in_comp};

    always_ff @(posedge aclk) begin
        if (cwr) cmem[cwaddr] <= in_val;
        cmem_q <= cmem[ic_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cval_reg <= '0;
        end else if (cwr) begin
            cval_reg[cwaddr] <= 1'b1;
        end
        cval_q <= cval_reg[ic_reg];
    end

    // vector store and partition tags
    logic [VW-1:0] vmem [CAPACITY*DIM];
    logic [VW-1:0] vmem_q;
    logic [PW-1:0] tmem [CAPACITY];
    logic [PW-1:0] tmem_q;
    logic          vwr, twr;

    assign vwr = (state_reg == S_ADDWR);
    assign twr = vwr && c_reg == CW'(DIM-1);

    always_ff @(posedge aclk) begin
        if (vwr) vmem[{count_reg[IW-1:0], c_reg}] <= pend_reg[c_reg];
        vmem_q <= vmem[{id_reg[IW-1:0], c_reg}];
    end

    always_ff @(posedge aclk) begin
        if (twr) tmem[count_reg[IW-1:0]] <= best_p_reg;
        tmem_q <= tmem[id_reg[IW-1:0]];
    end

    // operand feed into the distance unit
    logic           iss_v;
    logic [CW-1:0]  iss_c;
    logic           iv_reg, ifirst_reg, ilast_reg, isrc_reg;
    logic signed [VW-1:0] ia_reg;
    dist_in_t       din;
    logic           dv;
    logic [DW-1:0]  dsum;

    assign iss_v = (state_reg == S_CDIST && issuing_reg) || state_reg == S_ISS;
    assign iss_c = (state_reg == S_CDIST) ? ic_reg[CW-1:0] : c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) iv_reg <= 1'b0;
        else          iv_reg <= iss_v;
        ifirst_reg <= iss_c == '0;
        ilast_reg  <= iss_c == CW'(DIM-1);
        isrc_reg   <= state_reg == S_CDIST;
        ia_reg     <= pend_reg[iss_c];
    end

    assign din.vld   = iv_reg;
    assign din.first = ifirst_reg;
    assign din.last  = ilast_reg;
    assign din.a     = ia_reg;
    assign din.b     = isrc_reg ? (cval_q ? cmem_q : '0) : vmem_q;

    ivfs_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .din     (din),
        .out_vld (dv),
        .out_sum (dsum)
    );

    // chain of best-neighbor cells
    cand_t chain_out [MAX_K];
    cand_t ent [MAX_K];

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        ivfs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clr      (clr_chain),
            .cand_in  ((g == 0) ? inj : chain_out[(g == 0) ? 0 : g-1]),
            .cand_out (chain_out[g]),
            .entry    (ent[g])
        );
    end

    assign inj.vld   = state_reg == S_WAIT && dv;
    assign inj.sqd   = dsum;
    assign inj.label = LW'(id_reg);
    assign clr_chain = state_reg == S_EMIT && !(m_tvalid_reg && !m_tready)
                       && oi_reg == kk - CFGW'(1);

    logic         m_free;
    logic         out_load;
    logic         sel_take;
    logic [PW-1:0] pick_now;
    cand_t        oent;

    assign m_free   = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_ONE || state_reg == S_EMIT) && m_free;
    assign sel_take = !mask_reg[pp_reg] && (!found_reg || pd_reg[pp_reg] < bd_reg);
    assign pick_now = sel_take ? pp_reg : pick_reg;
    assign oent     = ent[oi_reg[KW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issuing_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_mode == MODE_CLEAR) begin
                            count_reg <= '0;
                        end else if (in_mode != MODE_LOAD && in_comp == CW'(DIM-1)) begin
                            is_query_reg <= in_mode == MODE_QUERY;
                            o_part_reg   <= '0;
                            o_label_reg  <= LABEL_NONE;
                            if (in_mode == MODE_ADD && count_reg >= (IW+1)'(CAPACITY)) begin
                                o_kind_reg   <= KIND_ACK;
                                o_dist_reg   <= '0;
                                o_status_reg <= ST_FULL;
                                state_reg    <= S_ONE;
                            end else if (in_mode == MODE_QUERY && count_reg == '0) begin
                                o_kind_reg   <= KIND_QUERY;
                                o_dist_reg   <= DIST_MAX;
                                o_status_reg <= ST_EMPTY;
                                state_reg    <= S_ONE;
                            end else begin
                                ic_reg      <= '0;
                                issuing_reg <= 1'b1;
                                rc_reg      <= '0;
                                state_reg   <= S_CDIST;
                            end
                        end
                    end
                end
                S_CDIST: begin
                    if (issuing_reg) begin
                        ic_reg <= ic_reg + 1'b1;
                        if (ic_reg == '1) issuing_reg <= 1'b0;
                    end
                    if (dv) begin
                        pd_reg[rc_reg] <= dsum;
                        if (rc_reg == '0 || dsum < best_d_reg) begin
                            best_d_reg <= dsum;
                            best_p_reg <= rc_reg;
                        end
                        rc_reg <= rc_reg + 1'b1;
                        if (rc_reg == PW'(NPART-1)) begin
                            c_reg     <= '0;
                            mask_reg  <= '0;
                            pi_reg    <= '0;
                            pp_reg    <= '0;
                            found_reg <= 1'b0;
                            state_reg <= is_query_reg ? S_PSEL : S_ADDWR;
                        end
                    end
                end
                S_ADDWR: begin
                    c_reg <= c_reg + 1'b1;
                    if (c_reg == CW'(DIM-1)) begin
                        o_kind_reg   <= KIND_ACK;
                        o_label_reg  <= LW'(count_reg);
                        o_part_reg   <= best_p_reg;
                        o_dist_reg   <= '0;
                        o_status_reg <= ST_OK;
                        count_reg    <= count_reg + 1'b1;
                        state_reg    <= S_ONE;
                    end
                end
                S_PSEL: begin
                    if (sel_take) begin
                        bd_reg    <= pd_reg[pp_reg];
                        pick_reg  <= pp_reg;
                    end
                    found_reg <= (pp_reg != PW'(NPART-1)) && (found_reg || sel_take);
                    pp_reg <= pp_reg + 1'b1;
                    if (pp_reg == PW'(NPART-1)) begin
                        mask_reg[pick_now] <= 1'b1;
                        pi_reg    <= pi_reg + 1'b1;
                        if (pi_reg + 1'b1 == np) begin
                            id_reg    <= '0;
                            state_reg <= S_TAG;
                        end
                    end
                end
                S_TAG: begin
                    if (id_reg == count_reg) begin
                        oi_reg    <= '0;
                        c_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    c_reg <= '0;
                    if (mask_reg[tmem_q]) begin
                        state_reg <= S_ISS;
                    end else begin
                        id_reg    <= id_reg + 1'b1;
                        state_reg <= S_TAG;
                    end
                end
                S_ISS: begin
                    c_reg <= c_reg + 1'b1;
                    if (c_reg == CW'(DIM-1)) state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (dv) begin
                        id_reg    <= id_reg + 1'b1;
                        state_reg <= S_TAG;
                    end
                end
                S_DRAIN: begin
                    c_reg <= c_reg + 1'b1;
                    if (c_reg == CW'(DIM-1)) state_reg <= S_EMIT;
                end
                S_ONE: begin
                    if (m_free) begin
                        m_tuser_reg  <= o_kind_reg;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {3'b0, o_status_reg, o_dist_reg, o_part_reg,
                                         o_label_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (m_free) begin
                        m_tuser_reg  <= KIND_QUERY;
                        m_tlast_reg  <= oi_reg == kk - CFGW'(1);
                        m_tdata_reg  <= {3'b0, ST_OK,
                                         oent.vld ? oent.sqd : DIST_MAX,
                                         {PW{1'b0}},
                                         oent.vld ? oent.label : LABEL_NONE};
                        oi_reg <= oi_reg + 1'b1;
                        if (oi_reg == kk - CFGW'(1)) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
endmodule

// File: dv/tb.sv
// Testbench for the partitioned nearest-neighbor search engine: directed and random stimulus.
`timescale 1ns / 1ps
module tb;
    import ivfs_pkg::*;

    typedef int vec_t [DIM];
    typedef struct {
        logic          kind;
        logic [LW-1:0] label;
        logic [3:0]    part;
        logic [DW-1:0] sqd;
        logic [1:0]    st;
        logic          last;
    } nbr_t;
    typedef struct {
        logic [1:0]         mode;
        logic [3:0]         sel;
        logic signed [15:0] fill;
        bit                 typed;
        nbr_t               tv;
    } drow_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // partition_sel[3:0], component[7:4], value[23:8]
    logic [1:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;        // label[10:0], partition[14:11], distance[50:15], status[52:51]
    logic        m_tuser;        // kind
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ivf_flat_nearest_search dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // predictor state
    int         cent [NPART][DIM];
    int         vstore [CAPACITY][DIM];
    int         vtag [CAPACITY];
    int         vcount;
    vec_t       pend;
    logic [4:0] probe_reg = 1, topk_reg = 1;

    nbr_t neighbors_due[$];
    bit   use_typed;
    nbr_t typed_res;
    int   fails;
    int   sidle, ridle;
    bit   rx_hold;

    function automatic longint sqdist(vec_t a, vec_t b);
        longint s = 0;
        for (int i = 0; i < DIM; i++) s += longint'(a[i] - b[i]) * longint'(a[i] - b[i]);
        return (s > longint'(DIST_MAX)) ? longint'(DIST_MAX) : s;
    endfunction

    function automatic nbr_t mk(logic kind, logic [LW-1:0] label, logic [3:0] part,
                                logic [DW-1:0] sqd, logic [1:0] st, logic last);
        nbr_t r;
        r.kind = kind; r.label = label; r.part = part; r.sqd = sqd; r.st = st; r.last = last;
        return r;
    endfunction

    task automatic push_result(nbr_t r);
        nbr_t e;
        if (use_typed) e = typed_res;
        else e = r;
        neighbors_due.insert(neighbors_due.size(), e);
    endtask

    task automatic predict_add();
        longint bd = -1, d;
        int     best = 0;
        vec_t   c;
        if (vcount >= CAPACITY) begin
            push_result(mk(KIND_ACK, LABEL_NONE, 0, 0, ST_FULL, 1));
            return;
        end
        for (int p = 0; p < NPART; p++) begin
            c = cent[p];
            d = sqdist(pend, c);
            if (bd < 0 || d < bd) begin
                bd = d;
                best = p;
            end
        end
        for (int i = 0; i < DIM; i++) vstore[vcount][i] = pend[i];
        vtag[vcount] = best;
        push_result(mk(KIND_ACK, LABEL_NONE & vcount, best, 0, ST_OK, 1));
        vcount++;
    endtask

    task automatic predict_query();
        longint pd [NPART];
        longint bdist [MAX_K];
        int     blab [MAX_K];
        bit     probed [NPART];
        int     np, kk, nb, pos, pick, lim;
        longint bd, d;
        vec_t   c;
        if (vcount == 0) begin
            push_result(mk(KIND_QUERY, LABEL_NONE, 0, DIST_MAX, ST_EMPTY, 1));
            return;
        end
        np = (probe_reg == 0) ? 1 : (probe_reg > NPART ? NPART : probe_reg);
        kk = (topk_reg == 0) ? 1 : (topk_reg > MAX_K ? MAX_K : topk_reg);
        for (int p = 0; p < NPART; p++) begin
            c = cent[p];
            pd[p] = sqdist(pend, c);
            probed[p] = 0;
        end
        for (int i = 0; i < np; i++) begin
            bd = -1;
            pick = 0;
            for (int p = 0; p < NPART; p++)
                if (!probed[p] && (bd < 0 || pd[p] < bd)) begin
                    bd = pd[p];
                    pick = p;
                end
            probed[pick] = 1;
        end
        nb = 0;
        for (int id = 0; id < vcount; id++) begin
            if (!probed[vtag[id]]) continue;
            c = vstore[id];
            d = sqdist(pend, c);
            pos = nb;
            while (pos > 0 && bdist[pos-1] > d) pos--;
            if (pos >= kk) continue;
            lim = (nb < kk) ? nb : kk - 1;
            for (int j = lim; j > pos; j--) begin
                bdist[j] = bdist[j-1];
                blab[j] = blab[j-1];
            end
            bdist[pos] = d;
            blab[pos] = id;
            if (nb < kk) nb++;
        end
        for (int i = 0; i < kk; i++)
            if (i < nb) push_result(mk(KIND_QUERY, blab[i], 0, bdist[i], ST_OK, i + 1 == kk));
            else push_result(mk(KIND_QUERY, LABEL_NONE, 0, DIST_MAX, ST_OK, i + 1 == kk));
    endtask

    task automatic predict_beat(logic [1:0] mode, logic [3:0] sel, logic [3:0] comp,
                                logic signed [15:0] val);
        if (mode == MODE_CLEAR) vcount = 0;
        else if (mode == MODE_LOAD) cent[sel][comp] = val;
        else begin
            pend[comp] = val;
            if (comp == DIM - 1) begin
                if (mode == MODE_ADD) predict_add();
                else predict_query();
            end
        end
    endtask

    task automatic send_beat(logic [1:0] mode, logic [3:0] sel, logic [3:0] comp,
                             logic signed [15:0] val);
        if ($urandom_range(99) < sidle) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= {val, comp, sel};
        do @(posedge aclk); while (!s_tready);
        predict_beat(mode, sel, comp, val);
    endtask

    task automatic send_vector(logic [1:0] mode, bit mixed, vec_t v);
        logic [1:0] m;
        for (int i = 0; i < DIM; i++) begin
            m = (mixed && i != DIM - 1) ? ($urandom_range(1) ? MODE_ADD : MODE_QUERY) : mode;
            send_beat(m, $urandom_range(15), i, v[i]);
        end
    endtask

    task automatic settle();
        s_tvalid <= 0;
        wait (neighbors_due.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == 0) probe_reg = data[4:0];
        else topk_reg = data[4:0];
    endtask

    task automatic set_cfg(logic [4:0] probes, logic [4:0] k);
        settle();
        reg_write(3'd0, probes);
        reg_write(3'd4, k);
    endtask

    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t v;
        for (int i = 0; i < DIM; i++) v[i] = rand_val();
        return v;
    endfunction

    task automatic random_phase(int n_items);
        int   sent = 0;
        int   r;
        vec_t v;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 65) begin
                if (vcount == 0 && $urandom_range(3) != 0) send_vector(MODE_ADD, 0, rand_vec());
                else send_vector($urandom_range(1) ? MODE_ADD : MODE_QUERY,
                                 $urandom_range(7) == 0, rand_vec());
                sent += DIM;
            end else if (r < 95) begin
                send_beat(MODE_LOAD, $urandom_range(15), $urandom_range(15), rand_val());
                sent++;
            end else if (vcount > 12 || r == 99) begin
                send_beat(MODE_CLEAR, $urandom_range(15), $urandom_range(15), $urandom);
                sent++;
            end
        end
    endtask

    task automatic run_directed();
        drow_t rows [12];
        vec_t  v;
        rows[0]  = '{MODE_QUERY, 0, 0, 1, mk(KIND_QUERY, LABEL_NONE, 0, DIST_MAX, ST_EMPTY, 1)};
        rows[1]  = '{MODE_ADD, 0, 0, 1, mk(KIND_ACK, 0, 0, 0, ST_OK, 1)};
        rows[2]  = '{MODE_LOAD, 15, 16'sh7fff, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[3]  = '{MODE_LOAD, 3, 16'sh8000, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[4]  = '{MODE_ADD, 0, 16'sh7fff, 1, mk(KIND_ACK, 1, 15, 0, ST_OK, 1)};
        rows[5]  = '{MODE_ADD, 0, 16'sh8000, 1, mk(KIND_ACK, 2, 3, 0, ST_OK, 1)};
        rows[6]  = '{MODE_ADD, 0, 100, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[7]  = '{MODE_QUERY, 0, 16'sh8000, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[8]  = '{MODE_QUERY, 0, 16'sh7fff, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[9]  = '{MODE_CLEAR, 9, -1, 0, mk(0, 0, 0, 0, 0, 0)};
        rows[10] = '{MODE_QUERY, 0, 7, 1, mk(KIND_QUERY, LABEL_NONE, 0, DIST_MAX, ST_EMPTY, 1)};
        rows[11] = '{MODE_ADD, 0, 5, 1, mk(KIND_ACK, 0, 0, 0, ST_OK, 1)};
        foreach (rows[i]) begin
            use_typed = rows[i].typed;
            typed_res = rows[i].tv;
            for (int c = 0; c < DIM; c++) v[c] = rows[i].fill;
            case (rows[i].mode)
                MODE_CLEAR: send_beat(MODE_CLEAR, rows[i].sel, 0, rows[i].fill);
                MODE_LOAD: for (int c = 0; c < DIM; c++)
                    send_beat(MODE_LOAD, rows[i].sel, c, rows[i].fill);
                default: send_vector(rows[i].mode, 0, v);
            endcase
            use_typed = 0;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= ridle);
    end

    always @(posedge aclk) begin
        nbr_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (neighbors_due.size() == 0) begin
                $display("%0t unexpected beat: got %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fails++;
            end else begin
                e = neighbors_due.pop_front();
                if (m_tuser !== e.kind || m_tdata[10:0] !== e.label ||
                    m_tdata[14:11] !== e.part || m_tdata[50:15] !== e.sqd ||
                    m_tdata[52:51] !== e.st || m_tlast !== e.last) begin
                    $display("%0t mismatch: exp kind %b label %h part %h dist %h st %h last %b",
                             $time, e.kind, e.label, e.part, e.sqd, e.st, e.last);
                    $display("%0t            got kind %b label %h part %h dist %h st %h last %b",
                             $time, m_tuser, m_tdata[10:0], m_tdata[14:11], m_tdata[50:15],
                             m_tdata[52:51], m_tlast);
                    fails++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        for (int p = 0; p < NPART; p++)
            for (int i = 0; i < DIM; i++) cent[p][i] = 0;
        vcount = 0;
        fails = 0;
        use_typed = 0;
        rx_hold = 0;
        sidle = 34;
        ridle = 57;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        run_directed();
        set_cfg(16, 16);
        send_vector(MODE_QUERY, 0, rand_vec());

        set_cfg(0, 0);
        random_phase(40);
        set_cfg(31, 31);
        random_phase(10);

        sidle = 57;
        ridle = 34;
        set_cfg(3, 5);
        random_phase(40);

        sidle = 0;
        ridle = 0;
        set_cfg(2, 16);
        fork
            begin
                rx_hold = 1;
                repeat (4000) @(posedge aclk);
                rx_hold = 0;
            end
            begin
                for (int n = 0; n < 4; n++) send_vector(MODE_ADD, 0, rand_vec());
                for (int n = 0; n < 4; n++) send_vector(MODE_QUERY, 0, rand_vec());
            end
        join
        random_phase(30);

        set_cfg(1, 1);
        random_phase(20);

        settle();
        repeat (200) @(posedge aclk);
        if (fails == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
